### rtl/eiq_pkg.sv
// ----------------------------------------------------------------------------
// eiq_pkg
// Shared types and constants of the eCPRI IQ header parser and decimator.
// ----------------------------------------------------------------------------
package eiq_pkg;

    localparam int POS_W       = 13;
    localparam int PADDR_W     = 2;
    localparam int MAX_PAYLOAD = 4096;

    localparam logic [POS_W-1:0] PAY_LAST = POS_W'(MAX_PAYLOAD - 1);
    localparam logic [POS_W-1:0] POS_TOP  = 13'd8191;

    localparam logic [15:0] ECPRI_TYPE = 16'hAEFE;
    localparam logic [15:0] VLAN_TYPE  = 16'h8100;
    localparam logic [8:0]  PRB_FULL   = 9'd273;

    localparam logic [PADDR_W-1:0] ADDR_DECIM_PERIOD = 2'd0;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_of_packet;
        logic       direction;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        last_of_record;
        logic [7:0]  frame_number;
        logic [3:0]  subframe_number;
        logic [5:0]  slot_number;
        logic [5:0]  symbol_number;
        logic [11:0] section_number;
        logic [9:0]  first_prb;
        logic [8:0]  prb_count;
        logic [3:0]  compression_method;
        logic [3:0]  sample_width;
        logic        record_direction;
    } out_item_t;

    typedef struct packed {
        logic     valid;
        in_item_t item;
    } stage_t;

endpackage

### rtl/ecpri_iq_header_parse_decimate_core.sv
// ----------------------------------------------------------------------------
// ecpri_iq_header_parse_decimate_core
// Parses eCPRI IQ frames byte by byte and emits decimated payload records.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle and returns at most one
// payload item per byte, passing it through the input register and then
// the result register, with the header parse and packet decimation in a
// single pass of logic between the two. The sustained rate of one byte per
// cycle holds as long as the result side takes items, and a stall on the
// result side holds the input register and then lowers byte_ready.
module ecpri_iq_header_parse_decimate_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    output logic                        byte_ready,
    input  eiq_pkg::in_item_t           byte_item,
    output logic                        record_valid,
    input  logic                        record_ready,
    output eiq_pkg::out_item_t          record_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [eiq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import eiq_pkg::*;

    stage_t      stage;
    logic        take;
    logic [15:0] decim_period;

    eiq_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .decim_period (decim_period)
    );

    eiq_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .stage      (stage),
        .take       (take)
    );

    eiq_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .stage        (stage),
        .take         (take),
        .decim_period (decim_period),
        .record_valid (record_valid),
        .record_ready (record_ready),
        .record_item  (record_item)
    );

`ifndef SYNTHESIS
    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage.valid |-> byte_ready)
        else $error("Input register is empty but byte_ready is low.");

    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (stage.valid && (!record_valid || record_ready)))
        else $error("Parser took an item without room in the result register.");

    a_prb_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        record_valid |-> (record_item.prb_count != 9'd0))
        else $error("Result item carries a PRB count of zero.");

    a_stall_keeps_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (stage.valid && record_valid && !record_ready) |=> stage.valid)
        else $error("Input register lost its item during a result stall.");
`endif

endmodule

### rtl/eiq_cfg_regs.sv
// ----------------------------------------------------------------------------
// eiq_cfg_regs
// Configuration register file with its APB-style access port.
// ----------------------------------------------------------------------------
module eiq_cfg_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [eiq_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [15:0]                decim_period
);
    import eiq_pkg::*;

    logic [15:0] decim_period_reg;
    logic        wr_en;

    assign pready       = 1'b1;
    assign wr_en        = psel && penable && pwrite && pready;
    assign decim_period = decim_period_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_period_reg <= '0;
        end
        else if (wr_en && (paddr == ADDR_DECIM_PERIOD))
        begin
            decim_period_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_DECIM_PERIOD)
        begin
            prdata = {16'd0, decim_period_reg};
        end
    end

endmodule

### rtl/eiq_in_stage.sv
// ----------------------------------------------------------------------------
// eiq_in_stage
// Input register that holds one frame byte until the parser takes it.
// ----------------------------------------------------------------------------
module eiq_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  eiq_pkg::in_item_t byte_item,
    output eiq_pkg::stage_t   stage,
    input  logic              take
);
    import eiq_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    assign byte_ready  = !valid_reg || take;
    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_valid && byte_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            item_reg <= byte_item;
        end
    end

endmodule

### rtl/eiq_parser.sv
// ----------------------------------------------------------------------------
// eiq_parser
// Frame header parser, packet decimator and result register.
// ----------------------------------------------------------------------------
module eiq_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  eiq_pkg::stage_t    stage,
    output logic               take,
    input  logic [15:0]        decim_period,
    output logic               record_valid,
    input  logic               record_ready,
    output eiq_pkg::out_item_t record_item
);
    import eiq_pkg::*;

    localparam logic [POS_W-1:0] POS_TYPE_HI = 13'd12;
    localparam logic [POS_W-1:0] POS_TYPE_LO = 13'd13;
    localparam logic [POS_W-1:0] POS_TAG_HI  = 13'd16;
    localparam logic [POS_W-1:0] POS_TAG_LO  = 13'd17;
    localparam logic [POS_W-1:0] POS_HDR     = 13'd14;
    localparam logic [POS_W-1:0] REL_MSGTYPE = 13'd15;
    localparam logic [POS_W-1:0] REL_FLD_LO  = 13'd23;
    localparam logic [POS_W-1:0] REL_FLD_HI  = 13'd30;
    localparam logic [POS_W-1:0] REL_SELECT  = 13'd31;
    localparam logic [POS_W-1:0] REL_PAYLOAD = 13'd32;
    localparam logic [POS_W-1:0] TAG_OFFSET  = 13'd4;

    logic [POS_W-1:0] byte_position_reg, byte_position_next;
    logic             tagged_frame_reg, tagged_frame_next;
    logic [15:0]      type_shift_reg, type_shift_next;
    logic             packet_rejected_reg, packet_rejected_next;
    logic             packet_selected_reg, packet_selected_next;
    logic [63:0]      header_fields_reg, header_fields_next;
    logic             latched_direction_reg, latched_direction_next;
    logic [15:0]      sample_count_reg, sample_count_next;
    logic             record_valid_reg;
    out_item_t        record_item_reg;
    out_item_t        result_next;

    logic             can_load;
    logic             emit;
    logic [7:0]       b;
    logic             last;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] idx;
    logic [16:0]      count_inc;
    logic             rec_end;

    assign can_load     = !record_valid_reg || record_ready;
    assign take         = stage.valid && can_load;
    assign record_valid = record_valid_reg;
    assign record_item  = record_item_reg;
    assign b            = stage.item.packet_byte;
    assign last         = stage.item.last_of_packet;
    assign pos          = byte_position_reg;

    always_comb
    begin
        tagged_frame_next      = tagged_frame_reg;
        type_shift_next        = type_shift_reg;
        packet_rejected_next   = packet_rejected_reg;
        packet_selected_next   = packet_selected_reg;
        header_fields_next     = header_fields_reg;
        sample_count_next      = sample_count_reg;
        byte_position_next     = byte_position_reg;
        latched_direction_next = latched_direction_reg;
        emit                   = 1'b0;
        rec_end                = 1'b0;
        rel                    = '0;
        idx                    = '0;
        count_inc              = {1'b0, sample_count_reg} + 17'd1;

        if (pos == '0)
        begin
            latched_direction_next = stage.item.direction;
        end

        if (!packet_rejected_next)
        begin
            if ((pos == POS_TYPE_HI) || (pos == POS_TYPE_LO))
            begin
                type_shift_next = {type_shift_next[7:0], b};
            end
            if (pos == POS_TYPE_LO)
            begin
                if (type_shift_next == VLAN_TYPE)
                begin
                    tagged_frame_next = 1'b1;
                end
                else if (type_shift_next != ECPRI_TYPE)
                begin
                    packet_rejected_next = 1'b1;
                end
            end
            if (tagged_frame_next && ((pos == POS_TAG_HI) || (pos == POS_TAG_LO)))
            begin
                type_shift_next = {type_shift_next[7:0], b};
            end
            if (tagged_frame_next && (pos == POS_TAG_LO) && (type_shift_next != ECPRI_TYPE))
            begin
                packet_rejected_next = 1'b1;
            end
        end

        rel = pos - (tagged_frame_next ? TAG_OFFSET : '0);
        idx = rel - REL_PAYLOAD;

        if (!packet_rejected_next && (pos >= POS_HDR))
        begin
            if ((rel == REL_MSGTYPE) && (b != 8'd0))
            begin
                packet_rejected_next = 1'b1;
            end
            if ((rel >= REL_FLD_LO) && (rel <= REL_FLD_HI))
            begin
                header_fields_next = {header_fields_next[55:0], b};
            end
            if (!packet_rejected_next && (rel == REL_SELECT) && !last)
            begin
                if (decim_period == 16'd0)
                begin
                    packet_selected_next = 1'b1;
                end
                else if (count_inc < {1'b0, decim_period})
                begin
                    sample_count_next    = count_inc[15:0];
                    packet_selected_next = 1'b0;
                end
                else
                begin
                    sample_count_next    = '0;
                    packet_selected_next = 1'b1;
                end
            end
            if (packet_selected_next && (rel >= REL_PAYLOAD))
            begin
                emit    = 1'b1;
                rec_end = last || (idx >= PAY_LAST) || (pos == POS_TOP);
                if (rec_end)
                begin
                    packet_selected_next = 1'b0;
                end
            end
        end

        if (last)
        begin
            byte_position_next   = '0;
            tagged_frame_next    = 1'b0;
            type_shift_next      = '0;
            packet_rejected_next = 1'b0;
            packet_selected_next = 1'b0;
        end
        else if (byte_position_reg < POS_TOP)
        begin
            byte_position_next = byte_position_reg + 13'd1;
        end
    end

    always_comb
    begin
        result_next.payload_byte       = b;
        result_next.last_of_record     = rec_end;
        result_next.frame_number       = header_fields_reg[63:56];
        result_next.subframe_number    = header_fields_reg[55:52];
        result_next.slot_number        = header_fields_reg[51:46];
        result_next.symbol_number      = header_fields_reg[45:40];
        result_next.section_number     = header_fields_reg[39:28];
        result_next.first_prb          = header_fields_reg[25:16];
        result_next.prb_count          = (header_fields_reg[15:8] == 8'd0) ?
                                         PRB_FULL : {1'b0, header_fields_reg[15:8]};
        result_next.compression_method = header_fields_reg[3:0];
        result_next.sample_width       = header_fields_reg[7:4];
        result_next.record_direction   = latched_direction_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg     <= '0;
            tagged_frame_reg      <= 1'b0;
            type_shift_reg        <= '0;
            packet_rejected_reg   <= 1'b0;
            packet_selected_reg   <= 1'b0;
            header_fields_reg     <= '0;
            latched_direction_reg <= 1'b0;
            sample_count_reg      <= '0;
        end
        else if (take)
        begin
            byte_position_reg     <= byte_position_next;
            tagged_frame_reg      <= tagged_frame_next;
            type_shift_reg        <= type_shift_next;
            packet_rejected_reg   <= packet_rejected_next;
            packet_selected_reg   <= packet_selected_next;
            header_fields_reg     <= header_fields_next;
            latched_direction_reg <= latched_direction_next;
            sample_count_reg      <= sample_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            record_valid_reg <= take && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            record_item_reg <= result_next;
        end
    end

endmodule
